FILE: rtl/tqe_pkg.sv
`timescale 1ns / 1ps
package tqe_pkg;

  localparam int unsigned DataBytesDef    = 4096;
  localparam int unsigned ProgramWordsDef = 4096;

  localparam logic [2:0] TAG_INT  = 3'd1;
  localparam logic [2:0] TAG_NUM  = 3'd2;
  localparam logic [2:0] TAG_CHAR = 3'd3;
  localparam logic [2:0] TAG_LIT  = 3'd4;

  typedef enum logic [1:0] {
    KIND_EXEC = 2'd0,
    KIND_DATA = 2'd1,
    KIND_TAG  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_MUL    = 4'd1,
    OP_DIV    = 4'd2,
    OP_SUB    = 4'd3,
    OP_ASSIGN = 4'd4,
    OP_LT     = 4'd5,
    OP_LTE    = 4'd6,
    OP_GT     = 4'd7,
    OP_GTE    = 4'd8,
    OP_EQ     = 4'd9,
    OP_NEQ    = 4'd10,
    OP_GOTO   = 4'd11,
    OP_IN     = 4'd12,
    OP_OUT    = 4'd13
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_TYPE = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         opcode;
    logic [11:0]        addr_a;
    logic [11:0]        addr_b;
    logic [11:0]        addr_dest;
    logic signed [31:0] io_value;
  } req_t;

  typedef struct packed {
    logic [11:0]        next_pc;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               out_is_char;
    logic [1:0]         status;
  } rsp_t;

  function automatic logic is_int(input logic [2:0] t);
    return (t == TAG_INT) || (t == TAG_NUM);
  endfunction

  function automatic logic is_char(input logic [2:0] t);
    return (t == TAG_CHAR) || (t == TAG_LIT);
  endfunction

  function automatic logic tags_match(input logic [2:0] x, input logic [2:0] y);
    return (x == y) || (is_int(x) && is_int(y)) || (is_char(x) && is_char(y));
  endfunction

endpackage

FILE: rtl/tqe_if.sv
`timescale 1ns / 1ps
interface tqe_req_if;
  import tqe_pkg::*;
  logic valid;
  logic ready;
  req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface tqe_rsp_if;
  import tqe_pkg::*;
  logic valid;
  logic ready;
  rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

FILE: rtl/tqe_ram.sv
`timescale 1ns / 1ps
module tqe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/typed_quad_executor_core.sv
`timescale 1ns / 1ps
// A request wraps its addresses by repeated subtraction; exec requests then go through tag reads,
// up to four byte reads per operand, a 32-step divide and up to four byte writes, all through
// data and tag memories with one write port and one read port each.
// Throughput: one request at a time; the next is taken once the response has been taken.
// Reset: asynchronous, active low; afterwards a clearing pass over every address zeroes
// the tag memory, during which no request is accepted. The data memory is not cleared.
module typed_quad_executor_core #(
  parameter int unsigned DATA_BYTES    = tqe_pkg::DataBytesDef,
  parameter int unsigned PROGRAM_WORDS = tqe_pkg::ProgramWordsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tqe_req_if.sink   req_i,
  tqe_rsp_if.source rsp_o
);
  import tqe_pkg::*;

  localparam int AW  = $clog2(DATA_BYTES);
  localparam int AW1 = AW + 1;
  localparam int RW  = (AW1 > 12) ? AW1 : 12;
  localparam int PW1 = $clog2(PROGRAM_WORDS) + 1;
  localparam int PRW = (PW1 > 13) ? PW1 : 13;
  localparam logic [RW-1:0]  DLim = RW'(DATA_BYTES);
  localparam logic [AW:0]    DEnd = AW1'(DATA_BYTES);
  localparam logic [AW:0]    DLast = AW1'(DATA_BYTES - 1);
  localparam logic [PRW-1:0] PLim = PRW'(PROGRAM_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_TAG_A, S_TAG_B, S_TAG_CHK,
    S_RDX, S_RDY, S_EXEC, S_DIV, S_WR, S_RESP
  } state_e;

  state_e          state_q;
  logic [1:0]      kind_q;
  logic [3:0]      op_q;
  logic [31:0]     io_q;
  logic [RW-1:0]   a_q, b_q, d_q;
  logic [PRW-1:0]  t_q;
  logic [11:0]     pc_q;
  logic [2:0]      ta_q;
  logic            wide_q;
  logic [AW-1:0]   ptr_q;
  logic [2:0]      cnt_q;
  logic [31:0]     x_q, y_q, w_q, rem_q, quo_q;
  logic [4:0]      dcnt_q;
  logic            neg_q;
  logic [AW-1:0]   clr_q;
  rsp_t            rsp_q;

  logic            tag_we, data_we;
  logic [AW-1:0]   tag_waddr, tag_raddr, data_waddr, data_raddr;
  logic [2:0]      tag_wdata, tag_rdata;
  logic [7:0]      data_wdata, data_rdata;

  logic [2:0]      nb;
  logic [31:0]     x_new, x_ext, sum_r, q_new, q_sgn;
  logic [32:0]     rem_sh;
  logic            rem_ge;
  logic [PRW-1:0]  pc_sum;
  logic [11:0]     pc_inc;
  logic            red_done, take;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW:0] s;
    s = {1'b0, p} + 1'b1;
    return (s == DEnd) ? '0 : s[AW-1:0];
  endfunction

  tqe_ram #(.WIDTH(3), .DEPTH(DATA_BYTES)) u_tag_ram (
    .clk_i, .we_i(tag_we), .waddr_i(tag_waddr), .wdata_i(tag_wdata),
    .raddr_i(tag_raddr), .rdata_o(tag_rdata)
  );

  tqe_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_data_ram (
    .clk_i, .we_i(data_we), .waddr_i(data_waddr), .wdata_i(data_wdata),
    .raddr_i(data_raddr), .rdata_o(data_rdata)
  );

  assign nb       = wide_q ? 3'd4 : 3'd1;
  assign x_new    = {x_q[23:0], data_rdata};
  assign x_ext    = wide_q ? x_new : {{24{x_new[7]}}, x_new[7:0]};
  assign red_done = (a_q < DLim) && (b_q < DLim) && (d_q < DLim) && (t_q < PLim);
  assign pc_sum   = PRW'(pc_q) + 1'b1;
  assign pc_inc   = (pc_sum == PLim) ? 12'd0 : pc_sum[11:0];
  assign rem_sh   = {rem_q, quo_q[31]};
  assign rem_ge   = rem_sh >= {1'b0, y_q};
  assign q_new    = {quo_q[30:0], rem_ge};
  assign q_sgn    = neg_q ? (32'd0 - q_new) : q_new;

  always_comb begin
    case (op_q)
      OP_ADD:  sum_r = x_q + y_q;
      OP_SUB:  sum_r = x_q - y_q;
      OP_MUL:  sum_r = x_q * y_q;
      default: sum_r = x_q;
    endcase
    case (op_q)
      OP_LT:   take = $signed(x_q) <  $signed(y_q);
      OP_LTE:  take = $signed(x_q) <= $signed(y_q);
      OP_GT:   take = $signed(x_q) >  $signed(y_q);
      OP_GTE:  take = $signed(x_q) >= $signed(y_q);
      OP_EQ:   take = x_q == y_q;
      default: take = x_q != y_q;
    endcase
  end

  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = a_q[AW-1:0];
    tag_wdata  = io_q[2:0];
    tag_raddr  = a_q[AW-1:0];
    data_we    = 1'b0;
    data_waddr = a_q[AW-1:0];
    data_wdata = io_q[7:0];
    data_raddr = ptr_q;
    case (state_q)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_q;
        tag_wdata = 3'd0;
      end
      S_REDUCE: begin
        tag_we  = red_done && (kind_q == KIND_TAG);
        data_we = red_done && (kind_q == KIND_DATA);
      end
      S_TAG_B: begin
        tag_raddr = (op_q == OP_ASSIGN) ? d_q[AW-1:0] : b_q[AW-1:0];
      end
      S_WR: begin
        data_we    = 1'b1;
        data_waddr = ptr_q;
        data_wdata = w_q[31:24];
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_RESP);
  assign rsp_o.rsp   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kind_q  <= '0;
      op_q    <= '0;
      io_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      d_q     <= '0;
      t_q     <= '0;
      pc_q    <= '0;
      ta_q    <= '0;
      wide_q  <= 1'b0;
      ptr_q   <= '0;
      cnt_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      w_q     <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dcnt_q  <= '0;
      neg_q   <= 1'b0;
      clr_q   <= '0;
      rsp_q   <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if ({1'b0, clr_q} == DLast) state_q <= S_IDLE;
          else clr_q <= clr_q + 1'b1;
        end
        S_IDLE: begin
          if (req_i.valid) begin
            kind_q  <= req_i.req.kind;
            op_q    <= req_i.req.opcode;
            io_q    <= req_i.req.io_value;
            a_q     <= RW'(req_i.req.addr_a);
            b_q     <= RW'(req_i.req.addr_b);
            d_q     <= RW'(req_i.req.addr_dest);
            t_q     <= (req_i.req.opcode == OP_GOTO) ? PRW'(req_i.req.addr_a)
                                                     : PRW'(req_i.req.addr_dest);
            rsp_q   <= '0;
            state_q <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // wrap addresses and target by repeated subtraction
          if (a_q >= DLim) a_q <= a_q - DLim;
          if (b_q >= DLim) b_q <= b_q - DLim;
          if (d_q >= DLim) d_q <= d_q - DLim;
          if (t_q >= PLim) t_q <= t_q - PLim;
          if (red_done) begin
            if (kind_q == KIND_EXEC) begin
              state_q <= S_TAG_A;
            end else begin
              rsp_q.next_pc <= pc_q;
              state_q       <= S_RESP;
            end
          end
        end
        S_TAG_A: state_q <= S_TAG_B;
        S_TAG_B: begin
          ta_q    <= tag_rdata;
          wide_q  <= is_int(tag_rdata);
          state_q <= S_TAG_CHK;
        end
        S_TAG_CHK: begin
          ptr_q <= a_q[AW-1:0];
          cnt_q <= '0;
          x_q   <= '0;
          if (op_q <= OP_NEQ) begin
            if (!tags_match(ta_q, tag_rdata)) begin
              rsp_q.status  <= ST_TYPE;
              rsp_q.next_pc <= pc_q;
              state_q       <= S_RESP;
            end else begin
              state_q <= S_RDX;
            end
          end else if (op_q == OP_GOTO) begin
            pc_q          <= t_q[11:0];
            rsp_q.next_pc <= t_q[11:0];
            state_q       <= S_RESP;
          end else if ((op_q == OP_IN) && (wide_q || is_char(ta_q))) begin
            w_q     <= wide_q ? io_q : {io_q[7:0], 24'd0};
            state_q <= S_WR;
          end else if ((op_q == OP_OUT) && (wide_q || is_char(ta_q))) begin
            state_q <= S_RDX;
          end else begin
            pc_q          <= pc_inc;
            rsp_q.next_pc <= pc_inc;
            state_q       <= S_RESP;
          end
        end
        S_RDX, S_RDY: begin
          if (cnt_q != 3'd0) x_q <= x_new;
          if (cnt_q < nb) ptr_q <= ptr_inc(ptr_q);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == nb) begin
            x_q   <= '0;
            cnt_q <= '0;
            if (state_q == S_RDY) begin
              y_q     <= x_ext;
              x_q     <= y_q;
              state_q <= S_EXEC;
            end else if (op_q == OP_OUT) begin
              rsp_q.out_valid   <= 1'b1;
              rsp_q.out_is_char <= !wide_q;
              rsp_q.out_value   <= x_ext;
              pc_q              <= pc_inc;
              rsp_q.next_pc     <= pc_inc;
              state_q           <= S_RESP;
            end else begin
              // park the first operand in y until the second arrives
              y_q     <= x_ext;
              ptr_q   <= b_q[AW-1:0];
              state_q <= S_RDY;
            end
          end
        end
        S_EXEC: begin
          ptr_q  <= d_q[AW-1:0];
          cnt_q  <= '0;
          rem_q  <= '0;
          dcnt_q <= '0;
          if (op_q == OP_DIV) begin
            if (y_q == 32'd0) begin
              rsp_q.status  <= ST_DIV0;
              rsp_q.next_pc <= pc_q;
              state_q       <= S_RESP;
            end else begin
              quo_q   <= x_q[31] ? (32'd0 - x_q) : x_q;
              y_q     <= y_q[31] ? (32'd0 - y_q) : y_q;
              neg_q   <= x_q[31] ^ y_q[31];
              state_q <= S_DIV;
            end
          end else if (op_q >= OP_LT) begin
            pc_q          <= take ? t_q[11:0] : pc_inc;
            rsp_q.next_pc <= take ? t_q[11:0] : pc_inc;
            state_q       <= S_RESP;
          end else begin
            w_q     <= wide_q ? sum_r : {sum_r[7:0], 24'd0};
            state_q <= S_WR;
          end
        end
        S_DIV: begin
          rem_q  <= rem_ge ? 32'(rem_sh - {1'b0, y_q}) : rem_sh[31:0];
          quo_q  <= q_new;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 5'd31) begin
            w_q     <= wide_q ? q_sgn : {q_sgn[7:0], 24'd0};
            state_q <= S_WR;
          end
        end
        S_WR: begin
          w_q   <= {w_q[23:0], 8'd0};
          ptr_q <= ptr_inc(ptr_q);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == nb - 1'b1) begin
            pc_q          <= pc_inc;
            rsp_q.next_pc <= pc_inc;
            state_q       <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
